### hw/rtl/rrd_pkg.sv
package rrd_pkg;

  // Width of the Rice parameter register.
  localparam int unsigned KW = 5;

  // Width of the decoded residual.
  localparam int unsigned RESW = 32;

  // Width of the unary run counter.
  localparam int unsigned CNTW = 20;

  // Largest Rice parameter the decoder honors; larger settings saturate.
  localparam int unsigned MAX_K = 31;

  // Longest unary run accepted before the code is abandoned.
  localparam logic [CNTW-1:0] RUNAWAY_LIMIT = CNTW'(1000000);

  // One code bit tagged with the Rice parameter in force when it arrived.
  typedef struct packed {
    logic          code_bit;
    logic [KW-1:0] k;
  } rrd_item_t;

  // One decoded result.
  typedef struct packed {
    logic signed [RESW-1:0] residual;
    logic                   runaway_error;
  } rrd_result_t;

endpackage

### hw/rtl/rrd_front.sv
module rrd_front #(
  parameter int unsigned MaxK = rrd_pkg::MAX_K
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic                     code_bit_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rrd_pkg::KW-1:0]   cfg_data_i,
  output logic                     item_valid_o,
  output rrd_pkg::rrd_item_t       item_o,
  input  logic                     item_take_i
);

  logic [rrd_pkg::KW-1:0] rice_k_q;
  logic [rrd_pkg::KW-1:0] eff_k;
  rrd_pkg::rrd_item_t     mem_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             cnt_q, cnt_d;
  logic                   wr_en, rd_en;

  // The parameter register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rice_k_q <= '0;
    end else if (cfg_valid_i) begin
      rice_k_q <= cfg_data_i;
    end
  end

  // Settings above the supported maximum saturate.
  assign eff_k = (rice_k_q > rrd_pkg::KW'(MaxK)) ? rrd_pkg::KW'(MaxK) : rice_k_q;

  // Two-entry queue toward the decode stage; each bit carries its own k.
  assign full         = (cnt_q == 2'd2);
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign rd_en        = item_valid_o && item_take_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= '{code_bit: code_bit_i, k: eff_k};
    end
  end

endmodule

### hw/rtl/rrd_back.sv
module rrd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  rrd_pkg::rrd_item_t                item_i,
  output logic                              item_take_o,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [rrd_pkg::RESW-1:0]   residual_o,
  output logic                              runaway_error_o
);

  localparam int unsigned RESW = rrd_pkg::RESW;
  localparam int unsigned CNTW = rrd_pkg::CNTW;
  localparam int unsigned KW   = rrd_pkg::KW;
  localparam int unsigned ACCW = rrd_pkg::RESW - 1;

  logic                in_rem_q, in_rem_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic [ACCW-1:0]     acc_q, acc_d;
  logic [ACCW-1:0]     acc_shift;
  logic [KW-1:0]       left_q, left_d;
  logic                emit;
  rrd_pkg::rrd_result_t res;
  logic [RESW-1:0]     mask, value;

  rrd_pkg::rrd_result_t oq_q [2];
  logic                 owr_q, ord_q;
  logic [1:0]           ocnt_q, ocnt_d;
  logic                 fire, ord_en;

  // A bit is decoded whenever the result queue has a free slot.
  assign fire        = item_valid_i && (ocnt_q != 2'd2);
  assign item_take_o = fire;

  // Remainder accumulator with the current bit shifted in.
  assign acc_shift = {acc_q[ACCW-2:0], item_i.code_bit};

  // Value assembly for the last remainder bit (or the terminator when k is zero).
  assign mask  = ~({RESW{1'b1}} << item_i.k);
  assign value = ({{(RESW-CNTW){1'b0}}, count_q} << item_i.k)
               | ({1'b0, acc_shift} & mask);

  // Decode step for one code bit.
  always_comb begin
    in_rem_d = in_rem_q;
    count_d  = count_q;
    acc_d    = acc_q;
    left_d   = left_q;
    emit     = 1'b0;
    res      = '{residual: '0, runaway_error: 1'b0};
    if (!in_rem_q) begin
      if (item_i.code_bit) begin
        if (count_q >= rrd_pkg::RUNAWAY_LIMIT) begin
          emit    = 1'b1;
          res     = '{residual: '0, runaway_error: 1'b1};
          count_d = '0;
        end else begin
          count_d = count_q + CNTW'(1);
        end
      end else if (item_i.k == '0) begin
        acc_d   = '0;
        emit    = 1'b1;
        count_d = '0;
      end else begin
        in_rem_d = 1'b1;
        acc_d    = '0;
        left_d   = item_i.k;
      end
    end else begin
      acc_d  = acc_shift;
      left_d = left_q - KW'(1);
      if (left_d == '0) begin
        emit     = 1'b1;
        in_rem_d = 1'b0;
        count_d  = '0;
        acc_d    = '0;
      end
    end
    if (emit && !res.runaway_error) begin
      res.residual = (value >> 1) ^ {RESW{value[0]}};
    end
  end

  // Decoder state advances only when a bit is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rem_q <= 1'b0;
      count_q  <= '0;
      acc_q    <= '0;
      left_q   <= '0;
    end else if (fire) begin
      in_rem_q <= in_rem_d;
      count_q  <= count_d;
      acc_q    <= acc_d;
      left_q   <= left_d;
    end
  end

  // Two-entry result queue; the oldest result sits on the ports.
  assign empty           = (ocnt_q == 2'd0);
  assign ord_en          = !empty && pop;
  assign residual_o      = oq_q[ord_q].residual;
  assign runaway_error_o = oq_q[ord_q].runaway_error;

  always_comb begin
    case ({fire && emit, ord_en})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
    end else begin
      ocnt_q <= ocnt_d;
      if (fire && emit) begin
        owr_q <= !owr_q;
      end
      if (ord_en) begin
        ord_q <= !ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      oq_q[owr_q] <= res;
    end
  end

endmodule

### hw/rtl/rice_residual_decoder_top.sv
// Bit-serial Rice decoder: one code bit is accepted per cycle while full is
// low, and full can rise only while the result queue is full. The bit ending
// a code word (the terminating zero when rice_k is zero, else the last
// remainder bit) passes through the registered two-entry bit queue and the
// combinational decode step of the back stage; its residual is registered
// into the two-entry result queue and sits on the result ports until popped.
// Each bit is tagged with rice_k at acceptance, so a write between code words
// takes effect from the next accepted bit. A unary run beyond one million
// ones yields a result with runaway_error set and residual zero.
module rice_residual_decoder_top #(
  parameter int unsigned MaxK = rrd_pkg::MAX_K
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            code_bit_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rrd_pkg::KW-1:0]          cfg_data_i,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [rrd_pkg::RESW-1:0] residual_o,
  output logic                            runaway_error_o
);

  logic               item_valid;
  logic               item_take;
  rrd_pkg::rrd_item_t item;

  // Front: parameter register and bit queue.
  rrd_front #(.MaxK(MaxK)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_bit_i   (code_bit_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Back: decoder state and result queue.
  rrd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_take_o     (item_take),
    .empty           (empty),
    .pop             (pop),
    .residual_o      (residual_o),
    .runaway_error_o (runaway_error_o)
  );

endmodule

### hw/rtl/rrd_checker.sv
module rrd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            push,
  input logic                            full,
  input logic                            cfg_ready_o,
  input logic                            empty,
  input logic                            pop,
  input logic signed [rrd_pkg::RESW-1:0] residual_o,
  input logic                            runaway_error_o
);

  // A runaway result always carries a zero residual.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && runaway_error_o) |-> (residual_o == '0))
    else $error("runaway result with nonzero residual");

  // A result that is not taken stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(residual_o) && $stable(runaway_error_o)))
    else $error("waiting result changed");

  // Both queues come out of reset empty.
  assert property (@(posedge clk_i)
    (rst_ni && !$past(rst_ni)) |-> (empty && !full))
    else $error("queues not empty after reset");

  // The parameter register never refuses a write beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration write refused");

  // Input is never blocked while the result side is empty and no bit came in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full)) |=> !full)
    else $error("bit queue full while decoder is free");

endmodule

bind rice_residual_decoder_top rrd_checker u_rrd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .cfg_ready_o     (cfg_ready_o),
  .empty           (empty),
  .pop             (pop),
  .residual_o      (residual_o),
  .runaway_error_o (runaway_error_o)
);
